// ----- hw/rtl/layout_repetition_offset_expander_unit_macros.svh -----
// Assertion macros for the repetition offset expander.
// Used by the top level only; the bodies vanish when SYNTHESIS is defined.
`ifndef LAYOUT_REPETITION_OFFSET_EXPANDER_UNIT_MACROS_SVH
`define LAYOUT_REPETITION_OFFSET_EXPANDER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication under reset.
`define LROE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lroe check failed");
// Next-cycle implication under reset.
`define LROE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lroe check failed");
`else
`define LROE_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define LROE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- hw/rtl/lroe_pkg.sv -----
// Shared constants, codes, types and helpers for the repetition offset expander.
// No dependencies; imported by lroe_scale and the top level.
`timescale 1ns / 1ps
package lroe_pkg;

    localparam int COUNT_WIDTH  = 16;
    localparam int COORD_WIDTH  = 32;
    localparam int OFFSET_WIDTH = 64;
    localparam int HALF_WIDTH   = OFFSET_WIDTH / 2;
    localparam int PROD_WIDTH   = HALF_WIDTH + COORD_WIDTH;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_NEXT  = 1'b1;

    // Repetition types.
    localparam logic [3:0] REP_GRID_XY     = 4'd1;
    localparam logic [3:0] REP_ROW_X       = 4'd2;
    localparam logic [3:0] REP_COL_Y       = 4'd3;
    localparam logic [3:0] REP_IRR_X       = 4'd4;
    localparam logic [3:0] REP_IRR_X_GRID  = 4'd5;
    localparam logic [3:0] REP_IRR_Y       = 4'd6;
    localparam logic [3:0] REP_IRR_Y_GRID  = 4'd7;
    localparam logic [3:0] REP_ARRAY_2D    = 4'd8;
    localparam logic [3:0] REP_ARRAY_1D    = 4'd9;
    localparam logic [3:0] REP_IRR_XY      = 4'd10;
    localparam logic [3:0] REP_IRR_XY_GRID = 4'd11;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_IDLE     = 2'd1;
    localparam logic [1:0] STATUS_BAD_TYPE = 2'd2;

    // An unscaled offset with its scale factor and flags, on its way to the scaler.
    typedef struct packed {
        logic [OFFSET_WIDTH-1:0] pos_x;
        logic [OFFSET_WIDTH-1:0] pos_y;
        logic [COORD_WIDTH-1:0]  scale;
        logic                    last;
        logic [1:0]              status;
    } lroe_item_t;

    function automatic logic [OFFSET_WIDTH-1:0] sext_coord(input logic [COORD_WIDTH-1:0] v);
        return {{(OFFSET_WIDTH-COORD_WIDTH){v[COORD_WIDTH-1]}}, v};
    endfunction

endpackage

// ----- hw/rtl/lroe_scale.sv -----
// Two-stage grid scaler: multiplies each offset by its scale factor modulo 2^64.
// Depends on lroe_pkg; holds the product stage and the result register.
`timescale 1ns / 1ps
module lroe_scale (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  lroe_pkg::lroe_item_t                   in_item,
    output logic                                   result_valid,
    input  logic                                   result_ready,
    output logic signed [lroe_pkg::OFFSET_WIDTH-1:0] offset_x,
    output logic signed [lroe_pkg::OFFSET_WIDTH-1:0] offset_y,
    output logic                                   last,
    output logic [1:0]                             status
);
    import lroe_pkg::*;

    logic                    prod_valid_reg;
    logic [PROD_WIDTH-1:0]   lo_x_reg;
    logic [PROD_WIDTH-1:0]   lo_y_reg;
    logic [HALF_WIDTH-1:0]   hi_x_reg;
    logic [HALF_WIDTH-1:0]   hi_y_reg;
    logic                    prod_last_reg;
    logic [1:0]              prod_status_reg;

    logic                    result_valid_reg;
    logic [OFFSET_WIDTH-1:0] offset_x_reg;
    logic [OFFSET_WIDTH-1:0] offset_y_reg;
    logic                    last_reg;
    logic [1:0]              status_reg;

    logic load_result;
    logic load_prod;

    assign load_result = !result_valid_reg || result_ready;
    assign load_prod   = !prod_valid_reg || load_result;
    assign in_ready    = load_prod;

    // The 64 by 32 product is split at the half word: the upper half only
    // contributes its low 32 bits once shifted into place.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else if (load_prod)
        begin
            prod_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_prod && in_valid)
        begin
            lo_x_reg <= PROD_WIDTH'(in_item.pos_x[HALF_WIDTH-1:0]) * PROD_WIDTH'(in_item.scale);
            lo_y_reg <= PROD_WIDTH'(in_item.pos_y[HALF_WIDTH-1:0]) * PROD_WIDTH'(in_item.scale);
            hi_x_reg <= HALF_WIDTH'(in_item.pos_x[OFFSET_WIDTH-1:HALF_WIDTH] * in_item.scale);
            hi_y_reg <= HALF_WIDTH'(in_item.pos_y[OFFSET_WIDTH-1:HALF_WIDTH] * in_item.scale);
            prod_last_reg   <= in_item.last;
            prod_status_reg <= in_item.status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (load_result)
        begin
            result_valid_reg <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_result && prod_valid_reg)
        begin
            offset_x_reg <= OFFSET_WIDTH'(lo_x_reg) + {hi_x_reg, HALF_WIDTH'(0)};
            offset_y_reg <= OFFSET_WIDTH'(lo_y_reg) + {hi_y_reg, HALF_WIDTH'(0)};
            last_reg     <= prod_last_reg;
            status_reg   <= prod_status_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign offset_x     = offset_x_reg;
    assign offset_y     = offset_y_reg;
    assign last         = last_reg;
    assign status       = status_reg;

endmodule

// ----- hw/rtl/layout_repetition_offset_expander_unit.sv -----
// Top level of the repetition offset expander.
// Depends on lroe_pkg, lroe_scale and the assertion macro header.
`timescale 1ns / 1ps
`include "layout_repetition_offset_expander_unit_macros.svh"

// Expands a layout repetition descriptor (types 1 to 11) into placement
// offsets, one result for every request. A start request loads the
// descriptor and answers (0,0); each next request answers the following
// offset, with last set on the final one. The block takes one request per
// clock cycle while its internal stages have room. The descriptor state
// update with its 64-bit adders settles ahead of the edge that takes a
// request into a stage register, the split grid multiply is registered in
// the product stage and the final partial-product add in the result
// register. Back-pressure on the result side fills the internal stages
// before the request side is held off. No memory is used, so the block
// is ready straight after reset.
module layout_repetition_offset_expander_unit (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     item_valid,
    output logic                                     item_ready,
    input  logic                                     cmd,
    input  logic [3:0]                               rep_type,
    input  logic [lroe_pkg::COUNT_WIDTH-1:0]         count_a,
    input  logic [lroe_pkg::COUNT_WIDTH-1:0]         count_b,
    input  logic signed [lroe_pkg::COORD_WIDTH-1:0]  step_a_x,
    input  logic signed [lroe_pkg::COORD_WIDTH-1:0]  step_a_y,
    input  logic signed [lroe_pkg::COORD_WIDTH-1:0]  step_b_x,
    input  logic signed [lroe_pkg::COORD_WIDTH-1:0]  step_b_y,
    input  logic [lroe_pkg::COORD_WIDTH-1:0]         grid,
    input  logic signed [lroe_pkg::COORD_WIDTH-1:0]  spacing_x,
    input  logic signed [lroe_pkg::COORD_WIDTH-1:0]  spacing_y,
    output logic                                     result_valid,
    input  logic                                     result_ready,
    output logic signed [lroe_pkg::OFFSET_WIDTH-1:0] offset_x,
    output logic signed [lroe_pkg::OFFSET_WIDTH-1:0] offset_y,
    output logic                                     last,
    output logic [1:0]                               status
);
    import lroe_pkg::*;

    logic                    active_reg,   active_next;
    logic [3:0]              kind_reg,     kind_next;
    logic [COUNT_WIDTH-1:0]  limit_a_reg,  limit_a_next;
    logic [COUNT_WIDTH-1:0]  limit_b_reg,  limit_b_next;
    logic [COUNT_WIDTH:0]    index_a_reg,  index_a_next;
    logic [COUNT_WIDTH:0]    index_b_reg,  index_b_next;
    logic [COORD_WIDTH-1:0]  pitch_ax_reg, pitch_ax_next;
    logic [COORD_WIDTH-1:0]  pitch_ay_reg, pitch_ay_next;
    logic [COORD_WIDTH-1:0]  pitch_bx_reg, pitch_bx_next;
    logic [COORD_WIDTH-1:0]  pitch_by_reg, pitch_by_next;
    logic [COORD_WIDTH-1:0]  grid_reg,     grid_next;
    logic [OFFSET_WIDTH-1:0] row_x_reg,    row_x_next;
    logic [OFFSET_WIDTH-1:0] row_y_reg,    row_y_next;
    logic [OFFSET_WIDTH-1:0] run_x_reg,    run_x_next;
    logic [OFFSET_WIDTH-1:0] run_y_reg,    run_y_next;

    logic       stage_valid_reg;
    lroe_item_t stage_item_reg;
    lroe_item_t item_next;

    logic accept;
    logic scale_ready;
    logic type_ok;
    logic is_regular, two_d, use_x, use_y, gridded;
    logic [COUNT_WIDTH:0] end_a, end_b;

    assign item_ready = !stage_valid_reg || scale_ready;
    assign accept     = item_valid && item_ready;
    assign type_ok    = (rep_type >= REP_GRID_XY) && (rep_type <= REP_IRR_XY_GRID);
    assign end_a      = {1'b0, limit_a_reg} + (COUNT_WIDTH+1)'(1);
    assign end_b      = {1'b0, limit_b_reg} + (COUNT_WIDTH+1)'(1);

    always_comb
    begin
        is_regular = 1'b0;
        two_d      = 1'b0;
        use_x      = 1'b0;
        use_y      = 1'b0;
        gridded    = 1'b0;
        case (kind_reg)
            REP_GRID_XY, REP_ARRAY_2D:
            begin
                is_regular = 1'b1;
                two_d      = 1'b1;
            end
            REP_ROW_X, REP_COL_Y, REP_ARRAY_1D: is_regular = 1'b1;
            REP_IRR_X:       use_x = 1'b1;
            REP_IRR_X_GRID:
            begin
                use_x   = 1'b1;
                gridded = 1'b1;
            end
            REP_IRR_Y:       use_y = 1'b1;
            REP_IRR_Y_GRID:
            begin
                use_y   = 1'b1;
                gridded = 1'b1;
            end
            REP_IRR_XY:
            begin
                use_x = 1'b1;
                use_y = 1'b1;
            end
            REP_IRR_XY_GRID:
            begin
                use_x   = 1'b1;
                use_y   = 1'b1;
                gridded = 1'b1;
            end
            default: is_regular = 1'b0;
        endcase
    end

    always_comb
    begin
        active_next   = active_reg;
        kind_next     = kind_reg;
        limit_a_next  = limit_a_reg;
        limit_b_next  = limit_b_reg;
        index_a_next  = index_a_reg;
        index_b_next  = index_b_reg;
        pitch_ax_next = pitch_ax_reg;
        pitch_ay_next = pitch_ay_reg;
        pitch_bx_next = pitch_bx_reg;
        pitch_by_next = pitch_by_reg;
        grid_next     = grid_reg;
        row_x_next    = row_x_reg;
        row_y_next    = row_y_reg;
        run_x_next    = run_x_reg;
        run_y_next    = run_y_reg;

        item_next.pos_x  = '0;
        item_next.pos_y  = '0;
        item_next.scale  = COORD_WIDTH'(1);
        item_next.last   = 1'b0;
        item_next.status = STATUS_OK;

        if (cmd == CMD_START)
        begin
            if (type_ok)
            begin
                // Only the pitch components that the type uses are kept.
                kind_next     = rep_type;
                limit_a_next  = count_a;
                limit_b_next  = '0;
                pitch_ax_next = '0;
                pitch_ay_next = '0;
                pitch_bx_next = '0;
                pitch_by_next = '0;
                case (rep_type)
                    REP_GRID_XY:
                    begin
                        limit_b_next  = count_b;
                        pitch_ax_next = step_a_x;
                        pitch_by_next = step_b_y;
                    end
                    REP_ROW_X:    pitch_ax_next = step_a_x;
                    REP_COL_Y:
                    begin
                        limit_a_next  = count_b;
                        pitch_ay_next = step_b_y;
                    end
                    REP_IRR_Y, REP_IRR_Y_GRID: limit_a_next = count_b;
                    REP_ARRAY_2D:
                    begin
                        limit_b_next  = count_b;
                        pitch_ax_next = step_a_x;
                        pitch_ay_next = step_a_y;
                        pitch_bx_next = step_b_x;
                        pitch_by_next = step_b_y;
                    end
                    REP_ARRAY_1D:
                    begin
                        pitch_ax_next = step_a_x;
                        pitch_ay_next = step_a_y;
                    end
                    default: limit_b_next = '0;
                endcase
                grid_next    = grid;
                index_a_next = '0;
                index_b_next = '0;
                row_x_next   = '0;
                row_y_next   = '0;
                run_x_next   = '0;
                run_y_next   = '0;
                active_next  = 1'b1;
            end
            else
            begin
                active_next      = 1'b0;
                item_next.status = STATUS_BAD_TYPE;
            end
        end
        else if (!active_reg)
        begin
            item_next.status = STATUS_IDLE;
        end
        else if (is_regular)
        begin
            // Raster walk: the inner index moves along B until the row is done,
            // then the row base steps by A and the inner index restarts.
            if (two_d && (index_b_reg < end_b))
            begin
                index_b_next = index_b_reg + (COUNT_WIDTH+1)'(1);
                run_x_next   = run_x_reg + sext_coord(pitch_bx_reg);
                run_y_next   = run_y_reg + sext_coord(pitch_by_reg);
            end
            else
            begin
                index_a_next = index_a_reg + (COUNT_WIDTH+1)'(1);
                index_b_next = '0;
                row_x_next   = row_x_reg + sext_coord(pitch_ax_reg);
                row_y_next   = row_y_reg + sext_coord(pitch_ay_reg);
                run_x_next   = row_x_next;
                run_y_next   = row_y_next;
            end
            item_next.pos_x = run_x_next;
            item_next.pos_y = run_y_next;
            item_next.last  = (index_a_next == end_a) && (!two_d || (index_b_next == end_b));
        end
        else
        begin
            index_a_next = index_a_reg + (COUNT_WIDTH+1)'(1);
            if (use_x)
            begin
                run_x_next = run_x_reg + sext_coord(spacing_x);
            end
            if (use_y)
            begin
                run_y_next = run_y_reg + sext_coord(spacing_y);
            end
            item_next.pos_x = run_x_next;
            item_next.pos_y = run_y_next;
            if (gridded)
            begin
                item_next.scale = grid_reg;
            end
            item_next.last = (index_a_next == end_a);
        end

        if (item_next.last)
        begin
            active_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg      <= 1'b0;
            kind_reg        <= '0;
            limit_a_reg     <= '0;
            limit_b_reg     <= '0;
            index_a_reg     <= '0;
            index_b_reg     <= '0;
            pitch_ax_reg    <= '0;
            pitch_ay_reg    <= '0;
            pitch_bx_reg    <= '0;
            pitch_by_reg    <= '0;
            grid_reg        <= '0;
            row_x_reg       <= '0;
            row_y_reg       <= '0;
            run_x_reg       <= '0;
            run_y_reg       <= '0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                active_reg   <= active_next;
                kind_reg     <= kind_next;
                limit_a_reg  <= limit_a_next;
                limit_b_reg  <= limit_b_next;
                index_a_reg  <= index_a_next;
                index_b_reg  <= index_b_next;
                pitch_ax_reg <= pitch_ax_next;
                pitch_ay_reg <= pitch_ay_next;
                pitch_bx_reg <= pitch_bx_next;
                pitch_by_reg <= pitch_by_next;
                grid_reg     <= grid_next;
                row_x_reg    <= row_x_next;
                row_y_reg    <= row_y_next;
                run_x_reg    <= run_x_next;
                run_y_reg    <= run_y_next;
            end
            if (item_ready)
            begin
                stage_valid_reg <= accept;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_item_reg <= item_next;
        end
    end

    lroe_scale u_scale (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (stage_valid_reg),
        .in_ready     (scale_ready),
        .in_item      (stage_item_reg),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .offset_x     (offset_x),
        .offset_y     (offset_y),
        .last         (last),
        .status       (status)
    );

    // An error answer never carries an offset and never ends a repetition.
    `LROE_ASSERT_NOW(a_error_is_blank, clk, rst_n,
        result_valid && (status != STATUS_OK),
        (offset_x == '0) && (offset_y == '0) && !last)

    // A well-formed start request always leaves a repetition running.
    `LROE_ASSERT_NEXT(a_start_activates, clk, rst_n,
        accept && (cmd == CMD_START) && type_ok,
        active_reg && (index_a_reg == '0) && (index_b_reg == '0))

    // A next request while idle must not move the walk.
    `LROE_ASSERT_NEXT(a_idle_next_holds, clk, rst_n,
        accept && (cmd == CMD_NEXT) && !active_reg,
        !active_reg && $stable(index_a_reg) && $stable(run_x_reg) && $stable(run_y_reg))

    // The final offset of a repetition closes it.
    `LROE_ASSERT_NEXT(a_last_closes, clk, rst_n,
        accept && item_next.last,
        !active_reg)

endmodule
